// ===== rtl/core/lzrw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrw_pkg
// Shared types and constants of the ring-window decompressor: parse phases,
// the command passed from the parser to the copy engine, the result beat.
// ----------------------------------------------------------------------------
package lzrw_pkg;

  localparam int unsigned CmdDepth = 4;
  localparam int unsigned OutDepth = 4;
  localparam logic [11:0] StartPos = 12'hFEE;
  localparam logic [7:0]  FlagFill = 8'hFF;
  localparam logic [4:0]  MinMatch = 5'd3;

  typedef enum logic [1:0] {
    PH_FLAG   = 2'd0,
    PH_TOKEN  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  // literal byte travels in arg[7:0]
  typedef struct packed {
    logic        restart;
    logic        literal;
    logic [11:0] arg;
    logic [3:0]  len;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_t;

endpackage

// ===== rtl/core/lzss_ring_window_decompressor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_ring_window_decompressor_top
// LZSS decompressor with a 4096-byte ring window and 3 to 18 byte matches.
// ----------------------------------------------------------------------------
// Compressed payload beats enter through push/full, header already removed;
// stream_start_i on a beat restarts parsing, the byte count and the window
// position. Decompressed bytes leave through empty/pop, oldest first, with
// run_last_o set on the last byte produced by one input beat.
// payload_length_i is written through cfg_valid_i/cfg_ready_o while idle
// (user's rule, unenforced); beats past that length are taken and dropped.
// The parser takes one beat per cycle while full is low, into a four-entry
// command queue. The copy engine emits one byte per cycle while the result
// queue has room, reading each match byte by byte through the single window
// read port.
// After reset the window is swept to zero with full high.
// When pop stalls, the four-beat result queue fills, the copy engine holds,
// the command queue fills and full rises.
// ----------------------------------------------------------------------------
module lzss_ring_window_decompressor_top
  import lzrw_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        stream_start_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] payload_length_i
);

  logic cmd_push, cmd_full, cmd_empty, cmd_pop, clearing, acc;
  cmd_t cmd_in, cmd_out;

  assign full        = cmd_full || clearing;
  assign acc         = push && !full;
  assign cfg_ready_o = 1'b1;

  lzrw_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .acc_i            (acc),
    .data_byte_i      (data_byte_i),
    .stream_start_i   (stream_start_i),
    .cfg_we_i         (cfg_valid_i),
    .payload_length_i (payload_length_i),
    .cmd_push_o       (cmd_push),
    .cmd_o            (cmd_in)
  );

  lzrw_fifo #(
    .item_t (cmd_t),
    .DEPTH  (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .item_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .item_o  (cmd_out),
    .empty_o (cmd_empty),
    .count_o ()
  );

  lzrw_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

// ===== rtl/core/lzrw_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrw_fifo
// Small register queue with fill count, used for commands and results.
// ----------------------------------------------------------------------------
module lzrw_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  item_t                        item_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output item_t                        item_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         store_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign item_o  = store_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/core/lzrw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrw_front
// Token parser: tracks flag bits, payload byte count and reference halves,
// and turns accepted literal and reference beats into literal or copy commands.
// ----------------------------------------------------------------------------
module lzrw_front
  import lzrw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic [7:0]  data_byte_i,
  input  logic        stream_start_i,
  input  logic        cfg_we_i,
  input  logic [23:0] payload_length_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o
);

  phase_e      phase_q, phase_d, phase_eff;
  logic [15:0] flag_q, flag_d, flag_eff, flag_shr;
  logic [7:0]  off_lo_q, off_lo_d, off_lo_eff;
  logic [23:0] consumed_q, consumed_d, consumed_eff;
  logic [23:0] len_q;
  logic        restart_q, restart_d, restart_eff;
  logic        live;

  assign phase_eff    = stream_start_i ? PH_FLAG : phase_q;
  assign flag_eff     = stream_start_i ? '0 : flag_q;
  assign off_lo_eff   = stream_start_i ? '0 : off_lo_q;
  assign consumed_eff = stream_start_i ? '0 : consumed_q;
  assign restart_eff  = stream_start_i || restart_q;
  assign flag_shr     = flag_eff >> 1;
  assign live         = acc_i && (consumed_eff < len_q);

  // next state
  always_comb begin
    phase_d    = phase_q;
    flag_d     = flag_q;
    off_lo_d   = off_lo_q;
    consumed_d = consumed_q;
    restart_d  = restart_q;
    if (acc_i) begin
      phase_d    = phase_eff;
      flag_d     = flag_eff;
      off_lo_d   = off_lo_eff;
      consumed_d = consumed_eff;
      restart_d  = restart_eff;
      if (live) begin
        consumed_d = consumed_eff + 24'd1;
        unique case (phase_eff)
          PH_TOKEN: begin
            if (flag_eff[0]) begin
              flag_d    = flag_shr;
              phase_d   = flag_shr[8] ? PH_TOKEN : PH_FLAG;
              restart_d = 1'b0;
            end else begin
              off_lo_d = data_byte_i;
              phase_d  = PH_SECOND;
            end
          end
          PH_SECOND: begin
            flag_d    = flag_shr;
            phase_d   = flag_shr[8] ? PH_TOKEN : PH_FLAG;
            restart_d = 1'b0;
          end
          default: begin
            flag_d  = {FlagFill, data_byte_i};
            phase_d = PH_TOKEN;
          end
        endcase
      end
    end
  end

  // command output
  always_comb begin
    cmd_push_o    = 1'b0;
    cmd_o.restart = restart_eff;
    cmd_o.literal = 1'b1;
    cmd_o.arg     = {4'd0, data_byte_i};
    cmd_o.len     = data_byte_i[3:0];
    if (live) begin
      unique case (phase_eff)
        PH_TOKEN: begin
          cmd_push_o = flag_eff[0];
        end
        PH_SECOND: begin
          cmd_push_o    = 1'b1;
          cmd_o.literal = 1'b0;
          cmd_o.arg     = {data_byte_i[7:4], off_lo_eff};
        end
        default: begin
          cmd_push_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FLAG;
      flag_q     <= '0;
      off_lo_q   <= '0;
      consumed_q <= '0;
      restart_q  <= 1'b0;
      len_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      flag_q     <= flag_d;
      off_lo_q   <= off_lo_d;
      consumed_q <= consumed_d;
      restart_q  <= restart_d;
      if (cfg_we_i) begin
        len_q <= payload_length_i;
      end
    end
  end

endmodule

// ===== rtl/core/lzrw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzrw_back
// Copy engine: runs literal and copy commands through the window memory one
// byte per cycle while the result queue has room, forwards a byte read in the
// cycle it is written, clears the window after reset and queues result beats.
// ----------------------------------------------------------------------------
module lzrw_back
  import lzrw_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       clearing_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  localparam int unsigned AW  = $clog2(WINDOW_DEPTH);
  localparam int unsigned OCW = $clog2(OutDepth + 1);

  typedef struct packed {
    logic       valid;
    logic       literal;
    logic [7:0] data;
    logic       last;
    logic       restart;
  } stage_t;

  logic [7:0]    window_q [WINDOW_DEPTH];
  logic [7:0]    rd_data_q;
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;

  logic          busy_q, busy_d;
  logic          lit_q, lit_d;
  logic [7:0]    byte_q, byte_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [4:0]    remain_q, remain_d;
  logic          restart_q, restart_d;

  stage_t        st_q, st_d;
  logic          byp_q;
  logic [7:0]    byp_data_q;
  logic [AW-1:0] wp_q, wr_addr;
  logic [7:0]    wdata;

  logic [OCW-1:0] out_cnt;
  logic           room, issue, last, load;
  logic           we;
  logic [AW-1:0]  we_addr;
  logic [7:0]     we_data;
  out_t           res_in, res_out;

  assign clearing_o = clr_q;
  assign room  = (out_cnt + OCW'(st_q.valid)) < OCW'(OutDepth);
  assign issue = busy_q && room && !clr_q;
  assign last  = (remain_q == 5'd1);
  assign load  = cmd_valid_i && (!busy_q || (issue && last));
  assign cmd_pop_o = load;

  assign wr_addr = st_q.restart ? AW'(StartPos) : wp_q;
  assign wdata   = st_q.literal ? st_q.data : (byp_q ? byp_data_q : rd_data_q);

  always_comb begin
    busy_d    = busy_q;
    lit_d     = lit_q;
    byte_d    = byte_q;
    rd_addr_d = rd_addr_q;
    remain_d  = remain_q;
    restart_d = restart_q;
    if (load) begin
      busy_d    = 1'b1;
      lit_d     = cmd_i.literal;
      byte_d    = cmd_i.arg[7:0];
      rd_addr_d = AW'(cmd_i.arg);
      remain_d  = cmd_i.literal ? 5'd1 : {1'b0, cmd_i.len} + MinMatch;
      restart_d = cmd_i.restart;
    end else if (issue) begin
      busy_d    = !last;
      rd_addr_d = rd_addr_q + AW'(1);
      remain_d  = remain_q - 5'd1;
      restart_d = 1'b0;
    end
  end

  always_comb begin
    st_d.valid   = issue;
    st_d.literal = lit_q;
    st_d.data    = byte_q;
    st_d.last    = last;
    st_d.restart = restart_q;
  end

  // window write port, shared with the clearing sweep
  always_comb begin
    if (clr_q) begin
      we      = 1'b1;
      we_addr = clr_cnt_q;
      we_data = '0;
    end else begin
      we      = st_q.valid;
      we_addr = wr_addr;
      we_data = wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      window_q[we_addr] <= we_data;
    end
    if (issue) begin
      rd_data_q <= window_q[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    lit_q      <= lit_d;
    byte_q     <= byte_d;
    rd_addr_q  <= rd_addr_d;
    remain_q   <= remain_d;
    restart_q  <= restart_d;
    byp_data_q <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      busy_q    <= 1'b0;
      st_q      <= '0;
      byp_q     <= 1'b0;
      wp_q      <= AW'(StartPos);
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(WINDOW_DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
      busy_q <= busy_d;
      st_q   <= st_d;
      byp_q  <= issue && st_q.valid && (rd_addr_q == wr_addr);
      if (st_q.valid) begin
        wp_q <= wr_addr + AW'(1);
      end
    end
  end

  assign res_in.data = wdata;
  assign res_in.last = st_q.last;

  // space for each beat is reserved at issue
  lzrw_fifo #(
    .item_t (out_t),
    .DEPTH  (OutDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (st_q.valid),
    .item_i  (res_in),
    .full_o  (),
    .pop_i   (pop_i),
    .item_o  (res_out),
    .empty_o (empty_o),
    .count_o (out_cnt)
  );

  assign out_byte_o = res_out.data;
  assign run_last_o = res_out.last;

endmodule
